// File: src/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// ntpc_pkg: shared types and constants
// Opcodes, field widths and the CORDIC arctangent table for the pursuit block.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam int CordicSteps = 16;
  localparam int IdBits      = 8;
  localparam int StepBits    = 5;

  typedef enum logic [1:0] {
    OP_POSE   = 2'd0,
    OP_TARGET = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_CLOSEST = 2'd0,
    REG_RADIUS  = 2'd1,
    REG_LGAIN   = 2'd2,
    REG_AGAIN   = 2'd3
  } reg_e;

  localparam logic [32:0] AllOnes33  = {33{1'b1}};
  localparam logic signed [14:0] PiQ12    = 15'sd12868;
  localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
  localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
  localparam logic [15:0] InvGainQ16 = 16'd39797;

  function automatic logic signed [31:0] atan_q28(input logic [StepBits-1:0] i);
    case (i)
      5'd0:  atan_q28 = 32'sd210828714;
      5'd1:  atan_q28 = 32'sd124459457;
      5'd2:  atan_q28 = 32'sd65760959;
      5'd3:  atan_q28 = 32'sd33381290;
      5'd4:  atan_q28 = 32'sd16755422;
      5'd5:  atan_q28 = 32'sd8385879;
      5'd6:  atan_q28 = 32'sd4193963;
      5'd7:  atan_q28 = 32'sd2097109;
      5'd8:  atan_q28 = 32'sd1048571;
      5'd9:  atan_q28 = 32'sd524287;
      5'd10: atan_q28 = 32'sd262144;
      5'd11: atan_q28 = 32'sd131072;
      5'd12: atan_q28 = 32'sd65536;
      5'd13: atan_q28 = 32'sd32768;
      5'd14: atan_q28 = 32'sd16384;
      5'd15: atan_q28 = 32'sd8192;
      5'd16: atan_q28 = 32'sd4096;
      5'd17: atan_q28 = 32'sd2048;
      5'd18: atan_q28 = 32'sd1024;
      5'd19: atan_q28 = 32'sd512;
      5'd20: atan_q28 = 32'sd256;
      5'd21: atan_q28 = 32'sd128;
      5'd22: atan_q28 = 32'sd64;
      5'd23: atan_q28 = 32'sd32;
      default: atan_q28 = 32'sd0;
    endcase
  endfunction

endpackage

// File: src/nearest_target_pursuit_controller_unit.sv
// ----------------------------------------------------------------------------
// nearest_target_pursuit_controller_unit: go-to-goal pursuit controller
// Takes nearest (first, closest off) list target; steers to it on ticks.
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   op in tuser; pos_x, pos_y, heading, target_id, first, last
// m_axis    out  linear_speed, turn_rate, caught, caught_id
// cfg       in   wr_en/index/data register writes
// Pose updates, ignored ops and refused ticks complete on acceptance; list
// elements pass through squared distance, then compare. A control tick runs
// load, 16 shift/add steps, scale, done, gain multiply and output load. The
// output load waits while an earlier result is still held; a held result
// does not block pose or list requests.
// Reset is asynchronous and restores register defaults; no clearing pass.
module nearest_target_pursuit_controller_unit import ntpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [46:32] heading, [54:47] target_id,
  // [55] first_of_list
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,  // last_of_list
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [17:0] linear_speed, [35:18] turn_rate, [36] caught, [44:37] caught_id,
  // [47:45] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_wr_en_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ELEM, S_CORDIC, S_CHECK, S_MUL, S_OUT
  } state_e;

  state_e state_q;

  logic        closest_q;
  logic [15:0] radius_q;
  logic [7:0]  lgain_q, again_q;
  logic [15:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q, best_x_q, best_y_q;
  logic [14:0] cur_head_q;
  logic        pose_seen_q, goal_valid_q;
  logic [IdBits-1:0] goal_id_q, best_id_q, elem_id_q;
  logic [32:0] best_d2_q, d2_q;
  logic [15:0] elem_x_q, elem_y_q;
  logic        elem_first_q, elem_last_q;

  logic [19:0] mag;
  logic signed [15:0] ang;
  logic        cdone, cstart;
  logic [19:0] mag_q;
  logic signed [17:0] err_q;
  logic [28:0] spd_prod_q;
  logic signed [26:0] turn_prod_q;
  logic        caught_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_load;

  logic [15:0] px, py;
  logic [14:0] hd;
  logic signed [16:0] ex, ey;
  logic [15:0] ax, ay;
  logic [31:0] ex2, ey2;
  logic signed [16:0] cdx, cdy;
  logic        open, take;
  logic signed [17:0] err0, errw;
  logic signed [27:0] spd_r;
  logic signed [22:0] turn_r;
  logic [17:0] spd_sat;
  logic [17:0] turn_sat;
  logic        accept;

  assign px = s_axis_tdata[15:0];
  assign py = s_axis_tdata[31:16];
  assign hd = s_axis_tdata[46:32];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  // result register loads only when no result is held or the held one is taken
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  assign ex = $signed({1'b0, elem_x_q}) - $signed({1'b0, cur_x_q});
  assign ey = $signed({1'b0, elem_y_q}) - $signed({1'b0, cur_y_q});
  // squares taken on magnitudes, 16x16 each
  assign ax = ex[16] ? 16'(-ex) : ex[15:0];
  assign ay = ey[16] ? 16'(-ey) : ey[15:0];
  assign ex2 = 32'(ax) * 32'(ax);
  assign ey2 = 32'(ay) * 32'(ay);
  assign cdx = $signed({1'b0, goal_x_q}) - $signed({1'b0, cur_x_q});
  assign cdy = $signed({1'b0, goal_y_q}) - $signed({1'b0, cur_y_q});

  assign open = elem_first_q || (best_d2_q == AllOnes33);
  assign take = closest_q ? (open || d2_q < best_d2_q) : open;

  assign cstart = (state_q == S_CORDIC);

  ntpc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart),
    .dx_i   (cdx),
    .dy_i   (cdy),
    .done_o (cdone),
    .mag_o  (mag),
    .ang_o  (ang)
  );

  always_comb begin
    err0 = 18'(ang) - 18'(signed'(cur_head_q));
    errw = err0;
    if (err0 > 18'(PiQ12)) errw = err0 - 18'(TwoPiQ12);
    else if (err0 < -18'(PiQ12)) errw = err0 + 18'(TwoPiQ12);
  end

  always_comb begin
    spd_r  = $signed({1'b0, spd_prod_q[26:0]}) + 28'sd8;
    turn_r = turn_prod_q[26:4] + 23'(turn_prod_q[3]);
    // spd_prod max below 2^28 + 8; rounding result width 25 bits
    if (spd_prod_q[28:27] != 2'b00 || (spd_r >>> 4) > 28'sd262143) spd_sat = 18'h3FFFF;
    else spd_sat = 18'(spd_r >>> 4);
    if (turn_r > 23'sd131071) turn_sat = 18'h1FFFF;
    else if (turn_r < -23'sd131072) turn_sat = 18'h20000;
    else turn_sat = turn_r[17:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closest_q <= 1'b1;
      radius_q <= 16'd2048;
      lgain_q <= 8'd32;
      again_q <= 8'd96;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        REG_CLOSEST: closest_q <= cfg_data_i[0];
        REG_RADIUS:  radius_q <= cfg_data_i;
        REG_LGAIN:   lgain_q <= cfg_data_i[7:0];
        REG_AGAIN:   again_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_x_q <= '0; cur_y_q <= '0; cur_head_q <= '0; pose_seen_q <= 1'b0;
      goal_x_q <= '0; goal_y_q <= '0; goal_id_q <= '0; goal_valid_q <= 1'b0;
      best_x_q <= '0; best_y_q <= '0; best_id_q <= '0; best_d2_q <= AllOnes33;
      caught_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(s_axis_tuser))
              OP_POSE: begin
                cur_x_q <= px; cur_y_q <= py; cur_head_q <= hd;
                pose_seen_q <= 1'b1;
              end
              OP_TARGET: begin
                elem_x_q <= px; elem_y_q <= py;
                elem_id_q <= s_axis_tdata[47 +: IdBits];
                elem_first_q <= s_axis_tdata[55];
                elem_last_q <= s_axis_tlast;
                state_q <= S_ELEM;
              end
              OP_TICK: if (pose_seen_q && goal_valid_q) state_q <= S_CORDIC;
              default: ;
            endcase
          end
        end
        S_ELEM: begin
          // squared distance registered, then compared next cycle
          d2_q <= 33'(ex2) + 33'(ey2);
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (take) begin
            best_x_q <= elem_x_q; best_y_q <= elem_y_q;
            best_id_q <= elem_id_q;
          end
          if (elem_last_q) begin
            goal_x_q <= take ? elem_x_q : best_x_q;
            goal_y_q <= take ? elem_y_q : best_y_q;
            goal_id_q <= take ? elem_id_q : best_id_q;
            goal_valid_q <= 1'b1;
            best_d2_q <= AllOnes33;
          end else if (take) begin
            best_d2_q <= d2_q;
          end
          state_q <= S_IDLE;
        end
        S_CORDIC: begin
          if (cdone) begin
            mag_q <= mag;
            err_q <= errw;
            if (mag <= 20'(radius_q)) begin
              caught_q <= 1'b1;
              goal_valid_q <= 1'b0;
            end else begin
              caught_q <= 1'b0;
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          spd_prod_q  <= 29'(mag_q) * 29'(lgain_q);
          turn_prod_q <= 27'(err_q) * 27'(signed'({1'b0, again_q}));
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (caught_q) out_data_q <= {3'b0, 8'(goal_id_q), 1'b1, 36'b0};
            else out_data_q <= {3'b0, 8'b0, 1'b0, turn_sat, spd_sat};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: src/ntpc_cordic.sv
// ----------------------------------------------------------------------------
// ntpc_cordic: iterative vectoring CORDIC
// One shift/add stage reused per step; gives Q20.0 magnitude, Q3.12 angle.
// ----------------------------------------------------------------------------
module ntpc_cordic import ntpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [16:0]  dx_i,
  input  logic signed [16:0]  dy_i,
  output logic                done_o,
  output logic [19:0]         mag_o,
  output logic signed [15:0]  ang_o
);

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_SCALE, S_DONE
  } state_e;

  state_e state_q;
  logic [StepBits-1:0] step_q;
  // x grows to about 1.65*sqrt(2)*2^24, y stays within that range
  logic signed [27:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [43:0] prod_q;

  logic signed [27:0] xs, ys, x0, y0;
  logic signed [31:0] z0;
  logic signed [31:0] zr;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;

  always_comb begin
    x0 = 28'(dx_i) <<< 8;
    y0 = 28'(dy_i) <<< 8;
    z0 = '0;
    if (dx_i < 0) begin
      if (dy_i >= 0) begin
        x0 = 28'(dy_i) <<< 8;
        y0 = -(28'(dx_i) <<< 8);
        z0 = HalfPiQ28;
      end else begin
        x0 = -(28'(dy_i) <<< 8);
        y0 = 28'(dx_i) <<< 8;
        z0 = -HalfPiQ28;
      end
    end
  end

  assign zr    = z_q + 32'sd32768;
  assign ang_o = zr[31:16];
  assign mag_o = prod_q[43:24];
  assign done_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            x_q <= x0; y_q <= y0; z_q <= z0;
            step_q <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (y_q > 0) begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q28(step_q);
          end else begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q28(step_q);
          end
          if (step_q == StepBits'(CordicSteps - 1)) state_q <= S_SCALE;
          step_q <= step_q + 1'b1;
        end
        S_SCALE: begin
          prod_q  <= 44'(unsigned'(x_q)) * 44'(InvGainQ16) + 44'(1 << 23);
          state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: pursuit controller regression
// Drives pose, target-list and tick requests with random gaps on both sides,
// predicts each steering command in a local model and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ntpc_pkg::*;

  localparam int MaxCycles = 1000000;

  // id in the top bits, speed in the low bits, as on m_axis_tdata
  typedef struct packed {
    logic [7:0]  id;
    logic        caught;
    logic [17:0] turn;
    logic [17:0] speed;
  } cmd_t;

  typedef struct {
    op_e         op;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] hdg;
    logic [7:0]  id;
    logic        first;
    logic        last;
    logic        has_exp;
    cmd_t        exp_cmd;
  } req_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_wr_en_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  nearest_target_pursuit_controller_unit DUT (.*);

  // predictor state
  logic        p_closest;
  logic [15:0] p_radius;
  logic [7:0]  p_lgain, p_again;
  logic [15:0] p_cx, p_cy, p_gx, p_gy, p_bx, p_by;
  logic [14:0] p_hdg;
  logic        p_pose, p_goal;
  logic [7:0]  p_gid, p_bid;
  logic [32:0] p_best;

  cmd_t   cmd_q[$];
  req_t   dir_tab[$];
  int     errors = 0;
  longint cycles = 0;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic void add_row(req_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void steer_reset();
    p_closest = 1; p_radius = 2048; p_lgain = 32; p_again = 96;
    p_cx = 0; p_cy = 0; p_hdg = 0; p_pose = 0;
    p_gx = 0; p_gy = 0; p_gid = 0; p_goal = 0;
    p_bx = 0; p_by = 0; p_bid = 0; p_best = AllOnes33;
  endfunction

  // returns 1 when the request yields a command
  function automatic bit steer_step(req_t r, output cmd_t c);
    longint dx, dy, d2, x, y, z, t, xs, ys, mag, ang, head, err, spd, trn;
    longint atans[24];
    bit open, take;
    atans = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
              4193963, 2097109, 1048571, 524287, 262144, 131072,
              65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    c = '0;
    case (r.op)
      OP_POSE: begin
        p_cx = r.x; p_cy = r.y; p_hdg = r.hdg; p_pose = 1;
        return 0;
      end
      OP_TARGET: begin
        dx = longint'(r.x) - longint'(p_cx);
        dy = longint'(r.y) - longint'(p_cy);
        d2 = dx * dx + dy * dy;
        open = r.first || p_best == AllOnes33;
        take = p_closest ? (open || d2 < longint'(p_best)) : open;
        if (take) begin
          p_bx = r.x; p_by = r.y; p_bid = r.id; p_best = d2[32:0];
        end
        if (r.last) begin
          p_gx = p_bx; p_gy = p_by; p_gid = p_bid; p_goal = 1; p_best = AllOnes33;
        end
        return 0;
      end
      OP_TICK: begin
        if (!(p_pose && p_goal)) return 0;
        x = (longint'(p_gx) - longint'(p_cx)) * 256;
        y = (longint'(p_gy) - longint'(p_cy)) * 256;
        z = 0;
        if (x < 0) begin
          if (y >= 0) begin t = x; x = y; y = -t; z = 421657428; end
          else begin t = x; x = -y; y = t; z = -421657428; end
        end
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
          xs = floor_sh(x, i); ys = floor_sh(y, i);
          if (y > 0) begin x += ys; y -= xs; z += atans[i]; end
          else begin x -= ys; y += xs; z -= atans[i]; end
        end
        mag = (x * 39797 + (longint'(1) << 23)) >>> 24;
        ang = floor_sh(z + 32768, 16);
        if (mag <= longint'(p_radius)) begin
          c.caught = 1; c.id = p_gid; p_goal = 0;
          return 1;
        end
        head = longint'($signed(p_hdg));
        err = ang - head;
        if (err > 12868) err -= 25736;
        else if (err < -12868) err += 25736;
        spd = floor_sh(mag * longint'(p_lgain) + 8, 4);
        spd = spd < 0 ? 0 : (spd > 262143 ? 262143 : spd);
        trn = floor_sh(err * longint'(p_again) + 8, 4);
        trn = trn < -131072 ? -131072 : (trn > 131071 ? 131071 : trn);
        c.speed = spd[17:0]; c.turn = trn[17:0];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    cmd_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[44:0];
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected command exp none got %h", $time, got);
      end else begin
        want = cmd_q.pop_front();
        if (got.speed !== want.speed)
          $display("%0t: speed exp %0d got %0d", $time, want.speed, got.speed);
        if (got.turn !== want.turn)
          $display("%0t: turn exp %0d got %0d", $time, $signed(want.turn), $signed(got.turn));
        if (got.caught !== want.caught)
          $display("%0t: caught exp %0d got %0d", $time, want.caught, got.caught);
        if (got.id !== want.id)
          $display("%0t: caught_id exp %0d got %0d", $time, want.id, got.id);
        if (got !== want) errors++;
      end
    end
  end

  // receiver stalls
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) m_axis_tready = 0;
      else m_axis_tready = 1;
      if ($urandom_range(0, 60) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(10, 80)) @(negedge clk_i);
      end
      if ($urandom_range(0, 9) < 3) begin
        m_axis_tready = 1;
        repeat ($urandom_range(5, 40)) @(negedge clk_i);
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_wr_en_i = 1; cfg_index_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_wr_en_i = 0;
    case (idx)
      REG_CLOSEST: p_closest = val[0];
      REG_RADIUS:  p_radius = val;
      REG_LGAIN:   p_lgain = val[7:0];
      default:     p_again = val[7:0];
    endcase
  endtask

  // sends one request at the falling edge, returns after acceptance
  task automatic send(req_t r);
    cmd_t c;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else if ($urandom_range(0, 40) == 0)
      repeat ($urandom_range(20, 100)) @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tuser = r.op;
    s_axis_tlast = r.last;
    s_axis_tdata = {r.first, r.id, r.hdg, r.y, r.x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (steer_step(r, c)) begin
      if (r.has_exp && c !== r.exp_cmd) begin
        errors++;
        $display("%0t: table row exp %h model %h", $time, r.exp_cmd, c);
      end
      cmd_q.insert(cmd_q.size(), c);
    end
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic req_t mk(op_e op, logic [15:0] x, logic [15:0] y, logic [14:0] h,
                              logic [7:0] id, logic f, logic l);
    req_t r;
    r.op = op; r.x = x; r.y = y; r.hdg = h; r.id = id; r.first = f; r.last = l;
    r.has_exp = 0; r.exp_cmd = '0;
    return r;
  endfunction

  function automatic req_t rand_req();
    int k;
    logic [15:0] bx, by;
    k = $urandom_range(0, 99);
    bx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192));
    by = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192));
    if (k < 20)
      return mk(OP_POSE, bx, by,
                $urandom_range(0, 9) == 0 ? 15'($urandom) :
                15'($urandom_range(0, 25736) - 12868), 8'($urandom), 0, 0);
    if (k < 60)
      return mk(OP_TARGET, bx, by, 15'($urandom), 8'($urandom),
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    if (k < 95)
      return mk(OP_TICK, bx, by, 15'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    return mk(OP_NONE, bx, by, 15'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  initial begin
    req_t r;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0; s_axis_tuser = OP_NONE;
    cfg_wr_en_i = 0; cfg_index_i = REG_CLOSEST; cfg_data_i = '0;
    steer_reset();
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // tick before pose/goal, unknown op, lists, catch, zero vector, extremes
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_NONE, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 1, 1));
    add_row(mk(OP_TARGET, 16'h1000, 0, 0, 8'h11, 0, 0));
    add_row(mk(OP_TARGET, 16'h0800, 0, 0, 8'h22, 0, 0));
    add_row(mk(OP_TARGET, 16'h0800, 0, 0, 8'h33, 0, 1));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_POSE, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_TARGET, 0, 0, 0, 8'hAA, 1, 1));
    r = mk(OP_TICK, 0, 0, 0, 0, 0, 0);
    r.has_exp = 1; r.exp_cmd = '{speed: 0, turn: 0, caught: 1, id: 8'hAA};
    add_row(r);
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_POSE, 16'hFFFF, 16'hFFFF, 15'sd12868, 0, 0, 0));
    add_row(mk(OP_TARGET, 16'h8000, 16'h8000, 0, 8'h01, 1, 0));
    add_row(mk(OP_TARGET, 0, 0, 0, 8'h02, 1, 0));
    add_row(mk(OP_TARGET, 16'h0000, 16'hFFFF, 0, 8'hFF, 0, 1));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_POSE, 0, 16'hFFFF, 15'h3FFF, 0, 0, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_POSE, 0, 16'hFFFF, 15'h4000, 0, 0, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_POSE, 16'hFFFF, 0, -15'sd12868, 0, 0, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    // each phase: new register setting, then random traffic
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_RADIUS, 16'd0); write_reg(REG_LGAIN, 16'd255);
                 write_reg(REG_AGAIN, 16'd255); end
        1: begin write_reg(REG_CLOSEST, 16'd0); write_reg(REG_RADIUS, 16'hFFFF); end
        2: begin write_reg(REG_RADIUS, 16'($urandom_range(0, 4096)));
                 write_reg(REG_LGAIN, 16'd0); write_reg(REG_AGAIN, 16'd0); end
        3: begin write_reg(REG_CLOSEST, 16'd1); write_reg(REG_LGAIN, 16'($urandom_range(0, 255)));
                 write_reg(REG_AGAIN, 16'($urandom_range(0, 255))); end
        4: begin write_reg(REG_CLOSEST, 16'd0); write_reg(REG_RADIUS, 16'd1024); end
        default: begin write_reg(REG_CLOSEST, 16'd1); write_reg(REG_RADIUS, 16'd2048);
                 write_reg(REG_LGAIN, 16'd32); write_reg(REG_AGAIN, 16'd96); end
      endcase
      for (int n = 0; n < 70; n++) send(rand_req());
      drain();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: nearest_target_pursuit_controller_unit.f
src/ntpc_pkg.sv
src/ntpc_cordic.sv
src/nearest_target_pursuit_controller_unit.sv
sim/tb_top.sv
